>>> rtl/rmt_pkg.sv
package rmt_pkg;

    localparam int unsigned NUM_REGS   = 5;
    localparam int unsigned ADDR_W     = 6;
    localparam int unsigned QUO_W      = 17;   // quotient bits of 2*num*4096/den
    localparam int unsigned REM_W      = 51;   // remainder / shifted divisor width
    localparam int unsigned DIV_STAGES = QUO_W + 2;  // prep + overflow + one per bit

    typedef enum logic [2:0] {
        REG_ROW0  = 3'd0,
        REG_ROW1  = 3'd1,
        REG_ROW2  = 3'd2,
        REG_ROW3  = 3'd3,
        REG_DIVW  = 3'd4
    } reg_idx_t;

    localparam logic signed [15:0] ONE_S312 = 16'sd4096;
    localparam logic signed [15:0] SAT_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] SAT_MIN  = 16'sh8000;

    // Per-item state that travels down the divide pipeline.
    typedef struct packed {
        logic                         row_end;
        logic                         div_en;
        logic                         zero;      // w accumulator is zero
        logic [3:0][15:0]             nd_res;    // non-divide results
        logic                         nd_clip;
        logic [2:0]                   nsign;     // numerator negative
        logic [2:0]                   nz;        // numerator nonzero
        logic                         dsign;     // w negative
        logic [32:0]                  ud;        // |w|
        logic [2:0][REM_W-1:0]        rem;
        logic [2:0]                   ovf;
        logic [2:0][QUO_W-1:0]        quo;
    } div_item_t;

endpackage

>>> rtl/rgba_matrix_transform_core.sv
// Stages: 22 in all (multiply, sum, prep, overflow check, 17 divide bit
//   stages, output).
// Throughput: one pixel per clock; every stage has its own valid bit and a
//   stalled output only holds stages that are occupied, so bubbles collapse.
// Reset: rst_n (async, active low) clears all valid bits and loads the
//   identity matrix with divide_by_w off.
module rgba_matrix_transform_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rmt_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    // pixel request in
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [15:0]          red_in,
    input  logic signed [15:0]          green_in,
    input  logic signed [15:0]          blue_in,
    input  logic signed [15:0]          alpha_in,
    input  logic                        row_end_in,
    // pixel request out
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [15:0]          red_out,
    output logic signed [15:0]          green_out,
    output logic signed [15:0]          blue_out,
    output logic signed [15:0]          alpha_out,
    output logic                        clipped,
    output logic                        zero_w,
    output logic                        row_end_out
);
    import rmt_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0][63:0] row_reg;
    logic             divw_reg;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= 64'h0000_0000_0000_1000;
            row_reg[1] <= 64'h0000_0000_1000_0000;
            row_reg[2] <= 64'h0000_1000_0000_0000;
            row_reg[3] <= 64'h1000_0000_0000_0000;
            divw_reg   <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cfg_idx)
                REG_ROW0: row_reg[0] <= pwdata;
                REG_ROW1: row_reg[1] <= pwdata;
                REG_ROW2: row_reg[2] <= pwdata;
                REG_ROW3: row_reg[3] <= pwdata;
                REG_DIVW: divw_reg   <= pwdata[0];
                default:  ;  // unmapped, dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ROW0: prdata = row_reg[0];
            REG_ROW1: prdata = row_reg[1];
            REG_ROW2: prdata = row_reg[2];
            REG_ROW3: prdata = row_reg[3];
            REG_DIVW: prdata = {63'd0, divw_reg};
            default:  prdata = 64'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: each stage advances if empty or the next one advances
    // ------------------------------------------------------------------
    logic                  mul_valid_reg, sum_valid_reg, out_valid_reg;
    logic [DIV_STAGES-1:0] dv_valid_reg;
    logic                  adv_mul, adv_sum, adv_out;
    logic [DIV_STAGES-1:0] adv_dv;

    assign adv_out = !out_valid_reg || !out_stall;
    always_comb
    begin
        adv_dv[DIV_STAGES-1] = !dv_valid_reg[DIV_STAGES-1] || adv_out;
        for (int i = DIV_STAGES-2; i >= 0; i--)
            adv_dv[i] = !dv_valid_reg[i] || adv_dv[i+1];
    end
    assign adv_sum  = !sum_valid_reg || adv_dv[0];
    assign adv_mul  = !mul_valid_reg || adv_sum;
    assign in_stall = !adv_mul;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            dv_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_mul)
                mul_valid_reg <= in_valid;
            if (adv_sum)
                sum_valid_reg <= mul_valid_reg;
            if (adv_dv[0])
                dv_valid_reg[0] <= sum_valid_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                if (adv_dv[i])
                    dv_valid_reg[i] <= dv_valid_reg[i-1];
            if (adv_out)
                out_valid_reg <= dv_valid_reg[DIV_STAGES-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: sixteen 16x16 products
    // ------------------------------------------------------------------
    logic [3:0][3:0][31:0] prod_reg;
    logic                  row_end_m_reg, row_end_s_reg;
    logic [3:0][15:0]      pix;

    assign pix = {alpha_in, blue_in, green_in, red_in};

    always_ff @(posedge clk)
    begin
        if (adv_mul)
        begin
            for (int i = 0; i < 4; i++)
                for (int c = 0; c < 4; c++)
                    prod_reg[i][c] <= 32'($signed(row_reg[i][16*c +: 16])
                                          * $signed(pix[c]));
            row_end_m_reg <= row_end_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: row sums, s9.24 in 34 bits
    // ------------------------------------------------------------------
    logic [3:0][33:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (adv_sum)
        begin
            for (int i = 0; i < 4; i++)
                acc_reg[i] <= 34'($signed(prod_reg[i][0])) + 34'($signed(prod_reg[i][1]))
                            + 34'($signed(prod_reg[i][2])) + 34'($signed(prod_reg[i][3]));
            row_end_s_reg <= row_end_m_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divide pipeline: prep, overflow check, then one quotient bit a stage
    // ------------------------------------------------------------------
    div_item_t dv_reg  [DIV_STAGES];
    div_item_t dv_next [DIV_STAGES];

    logic signed [34:0] rnd_sum [4];
    logic signed [22:0] rnd_sh  [4];
    logic [33:0]        neg_acc [3];
    logic [33:0]        neg_w;

    always_comb
    begin
        // prep stage: non-divide rounding/saturation and divide operands
        dv_next[0]         = '0;
        dv_next[0].row_end = row_end_s_reg;
        dv_next[0].div_en  = divw_reg;
        dv_next[0].zero    = (acc_reg[3] == 34'd0);
        for (int i = 0; i < 4; i++)
        begin
            rnd_sum[i] = 35'($signed(acc_reg[i])) + 35'sd2048;  // round half up
            rnd_sh[i]  = rnd_sum[i][34:12];
            if (rnd_sh[i] > 23'sd32767)
            begin
                dv_next[0].nd_res[i] = SAT_MAX;
                dv_next[0].nd_clip   = 1'b1;
            end
            else if (rnd_sh[i] < -23'sd32768)
            begin
                dv_next[0].nd_res[i] = SAT_MIN;
                dv_next[0].nd_clip   = 1'b1;
            end
            else
                dv_next[0].nd_res[i] = rnd_sh[i][15:0];
        end
        neg_w            = 34'd0 - acc_reg[3];
        dv_next[0].dsign = acc_reg[3][33];
        dv_next[0].ud    = acc_reg[3][33] ? neg_w[32:0] : acc_reg[3][32:0];
        for (int i = 0; i < 3; i++)
        begin
            neg_acc[i]          = 34'd0 - acc_reg[i];
            dv_next[0].nsign[i] = acc_reg[i][33];
            dv_next[0].nz[i]    = (acc_reg[i] != 34'd0);
            // dividend is 2 * |num| * 4096
            dv_next[0].rem[i]   = {5'd0, (acc_reg[i][33] ? neg_acc[i][32:0]
                                                         : acc_reg[i][32:0]), 13'd0};
        end

        // overflow stage: quotient would need more than QUO_W bits
        dv_next[1] = dv_reg[0];
        for (int i = 0; i < 3; i++)
            dv_next[1].ovf[i] = (dv_reg[0].rem[i]
                                 >= (REM_W'(dv_reg[0].ud) << QUO_W));

        // restoring bit stages, MSB first
        for (int s = 2; s < DIV_STAGES; s++)
        begin
            dv_next[s] = dv_reg[s-1];
            for (int i = 0; i < 3; i++)
            begin
                if (dv_reg[s-1].rem[i] >= (REM_W'(dv_reg[s-1].ud) << (DIV_STAGES-1-s)))
                begin
                    dv_next[s].rem[i] = dv_reg[s-1].rem[i]
                                        - (REM_W'(dv_reg[s-1].ud) << (DIV_STAGES-1-s));
                    dv_next[s].quo[i][DIV_STAGES-1-s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
            if (adv_dv[s])
                dv_reg[s] <= dv_next[s];
    end

    // ------------------------------------------------------------------
    // Final: round quotient, sign, saturate, merge with non-divide path
    // ------------------------------------------------------------------
    div_item_t          fin;
    logic [QUO_W:0]     q_rnd [3];
    logic [QUO_W-1:0]   q_mag [3];
    logic [3:0][15:0]   res_next;
    logic               clip_next;
    logic               zw_next;

    assign fin = dv_reg[DIV_STAGES-1];

    always_comb
    begin
        res_next  = fin.nd_res;
        clip_next = fin.nd_clip;
        zw_next   = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            q_rnd[i] = (QUO_W+1)'(fin.quo[i]) + 1'b1;   // ties away from zero
            q_mag[i] = q_rnd[i][QUO_W:1];
        end
        if (fin.div_en)
        begin
            res_next[3] = ONE_S312;
            clip_next   = 1'b0;
            zw_next     = fin.zero;
            for (int i = 0; i < 3; i++)
            begin
                if (fin.zero)
                begin
                    if (!fin.nz[i])
                        res_next[i] = 16'd0;
                    else
                    begin
                        res_next[i] = fin.nsign[i] ? SAT_MIN : SAT_MAX;
                        clip_next   = 1'b1;
                    end
                end
                else if (fin.nsign[i] ^ fin.dsign)
                begin
                    if (fin.ovf[i] || q_mag[i] > QUO_W'(32768))
                    begin
                        res_next[i] = SAT_MIN;
                        clip_next   = 1'b1;
                    end
                    else
                        res_next[i] = 16'(~q_mag[i] + 1'b1);
                end
                else
                begin
                    if (fin.ovf[i] || q_mag[i] > QUO_W'(32767))
                    begin
                        res_next[i] = SAT_MAX;
                        clip_next   = 1'b1;
                    end
                    else
                        res_next[i] = q_mag[i][15:0];
                end
            end
        end
    end

    logic [3:0][15:0] res_reg;
    logic             clip_reg, zw_reg, row_end_o_reg;

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            res_reg       <= res_next;
            clip_reg      <= clip_next;
            zw_reg        <= zw_next;
            row_end_o_reg <= fin.row_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_out     = res_reg[0];
    assign green_out   = res_reg[1];
    assign blue_out    = res_reg[2];
    assign alpha_out   = res_reg[3];
    assign clipped     = clip_reg;
    assign zero_w      = zw_reg;
    assign row_end_out = row_end_o_reg;

endmodule

>>> sim/tb_rgba_matrix_transform_core.sv
`timescale 1ns / 100ps

module tb_rgba_matrix_transform_core;
    import rmt_pkg::*;

    // One transformed pixel as the block reports it.
    typedef struct {
        logic signed [15:0] red;
        logic signed [15:0] green;
        logic signed [15:0] blue;
        logic signed [15:0] alpha;
        logic               clipped;
        logic               zero_w;
        logic               row_end;
    } pixel_t;

    // Color matrix predictor plus the queue of pixels still owed by the block.
    class pixel_scoreboard;
        logic [63:0] coef_row[4];
        logic        divide_on;
        pixel_t      owed[$];
        int          errors;

        function void reset_regs();
            coef_row[0] = 64'h1000;
            coef_row[1] = 64'h1000 << 16;
            coef_row[2] = 64'h1000 << 32;
            coef_row[3] = 64'h1000 << 48;
            divide_on   = 1'b0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [63:0] val);
            if (idx == REG_DIVW)
                divide_on = val[0];
            else
                coef_row[idx] = val;
        endfunction

        function longint sat(longint x, ref bit clip);
            if (x > 32767) begin
                clip = 1;
                return 32767;
            end
            if (x < -32768) begin
                clip = 1;
                return -32768;
            end
            return x;
        endfunction

        // num*4096/den, nearest, ties away from zero
        function longint ratio_s312(longint num, longint den);
            bit     neg;
            longint un;
            longint ud;
            longint q;
            neg = (num < 0) != (den < 0);
            un  = (num < 0 ? -num : num) <<< 12;
            ud  = den < 0 ? -den : den;
            q   = (2 * un + ud) / (2 * ud);
            if (q > 40000)
                q = 40000;
            return neg ? -q : q;
        endfunction

        function void note_request(logic signed [15:0] v[4], logic row_end);
            longint acc[4];
            longint res[4];
            longint k;
            bit     clip;
            pixel_t p;
            clip = 0;
            for (int i = 0; i < 4; i++)
            begin
                acc[i] = 0;
                for (int c = 0; c < 4; c++)
                begin
                    k = $signed(coef_row[i][16*c +: 16]);
                    acc[i] += k * longint'(v[c]);
                end
            end
            p.zero_w = 0;
            if (divide_on)
            begin
                res[3] = 4096;
                if (acc[3] == 0)
                begin
                    p.zero_w = 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        res[i] = acc[i] > 0 ? 32767 : (acc[i] < 0 ? -32768 : 0);
                        if (acc[i] != 0)
                            clip = 1;
                    end
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        res[i] = sat(ratio_s312(acc[i], acc[3]), clip);
                end
            end
            else
            begin
                // round half up: arithmetic shift floors
                for (int i = 0; i < 4; i++)
                    res[i] = sat((acc[i] + 2048) >>> 12, clip);
            end
            p.red     = res[0][15:0];
            p.green   = res[1][15:0];
            p.blue    = res[2][15:0];
            p.alpha   = res[3][15:0];
            p.clipped = clip;
            p.row_end = row_end;
            owed.insert(owed.size(), p);
        endfunction

        function void check_result(pixel_t got);
            pixel_t exp_p;
            if (owed.size() == 0)
            begin
                $error("unexpected result pixel");
                errors++;
                return;
            end
            exp_p = owed.pop_front();
            if (got.red !== exp_p.red)
            begin
                $error("red_out exp %0d got %0d", exp_p.red, got.red);
                errors++;
            end
            if (got.green !== exp_p.green)
            begin
                $error("green_out exp %0d got %0d", exp_p.green, got.green);
                errors++;
            end
            if (got.blue !== exp_p.blue)
            begin
                $error("blue_out exp %0d got %0d", exp_p.blue, got.blue);
                errors++;
            end
            if (got.alpha !== exp_p.alpha)
            begin
                $error("alpha_out exp %0d got %0d", exp_p.alpha, got.alpha);
                errors++;
            end
            if (got.clipped !== exp_p.clipped)
            begin
                $error("clipped exp %0b got %0b", exp_p.clipped, got.clipped);
                errors++;
            end
            if (got.zero_w !== exp_p.zero_w)
            begin
                $error("zero_w exp %0b got %0b", exp_p.zero_w, got.zero_w);
                errors++;
            end
            if (got.row_end !== exp_p.row_end)
            begin
                $error("row_end_out exp %0b got %0b", exp_p.row_end, got.row_end);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] red_in;
    logic signed [15:0] green_in;
    logic signed [15:0] blue_in;
    logic signed [15:0] alpha_in;
    logic               row_end_in;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] red_out;
    logic signed [15:0] green_out;
    logic signed [15:0] blue_out;
    logic signed [15:0] alpha_out;
    logic               clipped;
    logic               zero_w;
    logic               row_end_out;

    pixel_scoreboard sb;
    bit              calm;      // true during the no-idle stretch
    bit              sending;   // out_stall only toggles while traffic runs

    rgba_matrix_transform_core dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Hard limit: 550ish items, 12% idle per side.
    initial
    begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: random stall, result checked at each accepting edge.
    always @(posedge clk)
    begin
        pixel_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.red     = red_out;
            got.green   = green_out;
            got.blue    = blue_out;
            got.alpha   = alpha_out;
            got.clipped = clipped;
            got.zero_w  = zero_w;
            got.row_end = row_end_out;
            sb.check_result(got);
        end
        out_stall <= sending && !calm && ($urandom_range(99) < 12);
    end

    // APB write: setup then access; pready is tied high in the block.
    task automatic cfg_write(reg_idx_t idx, logic [63:0] val);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= ADDR_W'(8 * int'(idx));
        pwdata  <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // Send one pixel request; hold until accepted, optional idle before it.
    task automatic send_pixel(logic signed [15:0] r, logic signed [15:0] g,
                              logic signed [15:0] b, logic signed [15:0] a,
                              logic re);
        logic signed [15:0] v[4];
        while (!calm && $urandom_range(99) < 12)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid   <= 1;
        red_in     <= r;
        green_in   <= g;
        blue_in    <= b;
        alpha_in   <= a;
        row_end_in <= re;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        v[0] = r;
        v[1] = g;
        v[2] = b;
        v[3] = a;
        sb.note_request(v, re);
    endtask

    task automatic end_burst();
        in_valid <= 0;
        @(posedge clk);
    endtask

    // Wait until every owed pixel is back, then let the pipe drain.
    task automatic drain();
        sending = 1;
        while (sb.owed.size() != 0)
            @(posedge clk);
        sending = 0;
        repeat (30) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(signed'($urandom_range(8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_row();
        logic [63:0] r;
        for (int c = 0; c < 4; c++)
            r[16*c +: 16] = ($urandom_range(3) == 0) ? 16'($urandom)
                          : 16'(signed'($urandom_range(8192)) - 4096);
        return r;
    endfunction

    task automatic random_pixels(int n);
        for (int i = 0; i < n; i++)
            send_pixel(rand_sample(), rand_sample(), rand_sample(),
                       rand_sample(), $urandom_range(1));
        end_burst();
    endtask

    initial
    begin
        sb = new();
        sb.reset_regs();
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        in_valid = 0;
        red_in = 0;
        green_in = 0;
        blue_in = 0;
        alpha_in = 0;
        row_end_in = 0;
        out_stall = 0;
        calm = 0;
        sending = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Identity at reset: extremes and row end mark pass through.
        send_pixel(16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh1000, 1'b1);
        send_pixel(16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh0001, 1'b0);
        // All-max coefficients: every channel saturates both ways.
        end_burst();
        drain();
        for (int i = 0; i < 4; i++)
            cfg_write(reg_idx_t'(i), 64'h7FFF_7FFF_7FFF_7FFF);
        send_pixel(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pixel(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
        // Half-LSB rounding ties: 0.5 scaled by tiny inputs.
        end_burst();
        drain();
        for (int i = 0; i < 4; i++)
            cfg_write(reg_idx_t'(i), 64'h0800_0800_0800_0800);
        send_pixel(16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        send_pixel(16'shFFFF, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        send_pixel(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        end_burst();
        drain();

        // Divide mode: identity rows, then zero w, w of one, tiny w.
        cfg_write(REG_ROW0, 64'h1000);
        cfg_write(REG_ROW1, 64'h1000 << 16);
        cfg_write(REG_ROW2, 64'h1000 << 32);
        cfg_write(REG_ROW3, 64'h1000 << 48);
        cfg_write(REG_DIVW, 64'h1);
        send_pixel(16'sh0100, 16'shFF00, 16'sh0000, 16'sh0000, 1'b1);
        send_pixel(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        send_pixel(16'sh0800, 16'shF800, 16'sh7FFF, 16'sh1000, 1'b0);
        send_pixel(16'sh7FFF, 16'sh8000, 16'sh0001, 16'sh0001, 1'b0);
        send_pixel(16'sh0003, 16'shFFFD, 16'sh0001, 16'sh0002, 1'b1);
        send_pixel(16'sh7FFF, 16'sh8000, 16'sh1000, 16'sh8000, 1'b0);
        send_pixel(16'sh0001, 16'sh0001, 16'sh0001, 16'shFFFF, 1'b1);
        end_burst();
        drain();

        // Random phases; each reprograms the matrix and divide mode.
        for (int ph = 0; ph < 10; ph++)
        begin
            calm = (ph == 3);
            for (int i = 0; i < 4; i++)
                cfg_write(reg_idx_t'(i), (ph == 0) ? 64'h8000_8000_8000_8000
                                                   : rand_row());
            cfg_write(REG_DIVW, ph[0] ? 64'h1 : {$urandom, $urandom});
            random_pixels(55);
            drain();
        end
        calm = 0;

        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
